>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files of the path search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/gaps_pkg.sv
// Types, constants and helper functions of the grid path search block.
package gaps_pkg;

    localparam int ROW_W  = 3;
    localparam int DIM_W  = 4;
    localparam int COST_W = 6;
    localparam int F_W    = 7;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [2:0] REG_GRID_ROWS = 3'd0;
    localparam logic [2:0] REG_GRID_COLS = 3'd1;
    localparam logic [2:0] REG_START_ROW = 3'd2;
    localparam logic [2:0] REG_START_COL = 3'd3;
    localparam logic [2:0] REG_GOAL_ROW  = 3'd4;
    localparam logic [2:0] REG_GOAL_COL  = 3'd5;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_INIT,
        ST_CLEAR,
        ST_SEED,
        ST_SCAN_START,
        ST_SCAN,
        ST_TAKE_RD,
        ST_TAKE_WR,
        ST_EXP_RD,
        ST_EXP_WR,
        ST_NF,
        ST_TR_EMIT,
        ST_TR_STEP
    } state_t;

    typedef struct packed {
        logic       load_map;
        logic       init;
        logic       clear;
        logic       clear_wall;
        logic       seed;
        logic       scan_start;
        logic       scan_step;
        logic       take_rd;
        logic       take_wr;
        logic       expand;
        logic [1:0] dir;
        logic       nf_emit;
        logic       tr_emit;
        logic       tr_step;
    } cmd_t;

    typedef struct packed {
        logic start_ok;
        logic clear_done;
        logic open_empty;
        logic scan_done;
        logic is_goal;
        logic out_free;
        logic path_end;
    } status_t;

    function automatic logic [ROW_W:0] abs_diff(input logic [ROW_W-1:0] a,
                                                input logic [ROW_W-1:0] b);
        logic [ROW_W:0] d;
        begin
            d = (a > b) ? {1'b0, a} - {1'b0, b} : {1'b0, b} - {1'b0, a};
            return d;
        end
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] side);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0) begin
                r = DIM_W'(1);
            end else if (v > side) begin
                r = side;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

>>> sv/gaps_ctrl.sv
// Sequencing state machine of the grid path search block.
module gaps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              in_last,
    input  gaps_pkg::status_t sts,
    output logic              in_ready,
    output gaps_pkg::cmd_t    cmd
);
    import gaps_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] dir_reg, dir_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WIPE;
            dir_reg   <= DIR_UP;
        end else begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dir_next   = dir_reg;
        cmd        = '0;
        cmd.dir    = dir_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_WIPE: begin
                cmd.clear      = 1'b1;
                cmd.clear_wall = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready     = 1'b1;
                cmd.load_map = in_fire;
                if (in_fire && in_last) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = sts.start_ok ? ST_CLEAR : ST_NF;
            end
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED: begin
                cmd.seed   = 1'b1;
                state_next = ST_SCAN_START;
            end
            ST_SCAN_START: begin
                if (sts.open_empty) begin
                    state_next = ST_NF;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_TAKE_RD;
                end
            end
            ST_TAKE_RD: begin
                cmd.take_rd = 1'b1;
                state_next  = ST_TAKE_WR;
            end
            ST_TAKE_WR: begin
                cmd.take_wr = 1'b1;
                dir_next    = DIR_UP;
                state_next  = sts.is_goal ? ST_TR_EMIT : ST_EXP_RD;
            end
            ST_EXP_RD: begin
                state_next = ST_EXP_WR;
            end
            ST_EXP_WR: begin
                cmd.expand = 1'b1;
                dir_next   = dir_reg + 2'd1;
                state_next = (dir_reg == DIR_LEFT) ? ST_SCAN_START : ST_EXP_RD;
            end
            ST_NF: begin
                if (sts.out_free) begin
                    cmd.nf_emit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_TR_EMIT: begin
                if (sts.out_free) begin
                    cmd.tr_emit = 1'b1;
                    state_next  = sts.path_end ? ST_IDLE : ST_TR_STEP;
                end
            end
            ST_TR_STEP: begin
                cmd.tr_step = 1'b1;
                state_next  = ST_TR_EMIT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/gaps_dp.sv
// Datapath of the grid path search: maps, open list, best-entry scan and path output.
`include "assert_macros.svh"
module gaps_dp #(
    parameter int GRID_SIDE = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gaps_pkg::cmd_t                 cmd,
    output gaps_pkg::status_t              sts,
    input  logic [gaps_pkg::ROW_W-1:0]     in_row,
    input  logic [gaps_pkg::ROW_W-1:0]     in_col,
    input  logic                           in_blocked,
    input  logic [gaps_pkg::DIM_W-1:0]     cfg_rows,
    input  logic [gaps_pkg::DIM_W-1:0]     cfg_cols,
    input  logic [gaps_pkg::ROW_W-1:0]     cfg_start_row,
    input  logic [gaps_pkg::ROW_W-1:0]     cfg_start_col,
    input  logic [gaps_pkg::ROW_W-1:0]     cfg_goal_row,
    input  logic [gaps_pkg::ROW_W-1:0]     cfg_goal_col,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [gaps_pkg::ROW_W-1:0]     out_row,
    output logic [gaps_pkg::ROW_W-1:0]     out_col,
    output logic [gaps_pkg::COST_W-1:0]    out_cost,
    output logic                           out_found,
    output logic                           out_last
);
    import gaps_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int ENT_W = 2 * ROW_W + COST_W;
    localparam logic [DIM_W-1:0] SIDE = DIM_W'(GRID_SIDE);

    function automatic logic [AW-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                               input logic [ROW_W-1:0] c);
        return AW'(r * GRID_SIDE + c);
    endfunction

    // Wall and seen maps are one-bit memories with a registered read; a clearing
    // pass of one cell per cycle wipes the seen map for each search and both maps after reset.
    logic             wall_mem [CELLS];
    logic             seen_mem [CELLS];
    logic             wall_rd_reg, seen_rd_reg;
    logic             wall_we, wall_wdata;
    logic [AW-1:0]    wall_waddr;
    logic             seen_we, seen_wdata;
    logic [AW-1:0]    seen_waddr;
    logic [AW-1:0]    clr_idx_reg, clr_idx_next;

    logic [ENT_W-1:0] open_mem [CELLS];
    logic [1:0]       came_mem [CELLS];
    logic [ENT_W-1:0] open_rd_reg;
    logic [1:0]       came_rd_reg;
    logic [AW-1:0]    open_raddr;
    logic             open_we;
    logic [AW-1:0]    open_waddr;
    logic [ENT_W-1:0] open_wdata;
    logic             came_we;
    logic [AW-1:0]    came_waddr;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             cmp_v_reg, cmp_v_next;
    logic [CNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             best_v_reg, best_v_next;
    logic [F_W-1:0]   best_f_reg, best_f_next;
    logic [AW-1:0]    best_idx_reg, best_idx_next;
    logic [ROW_W-1:0] best_row_reg, best_row_next;
    logic [ROW_W-1:0] best_col_reg, best_col_next;
    logic [COST_W-1:0] best_g_reg, best_g_next;

    logic [ROW_W-1:0]  tr_row_reg, tr_row_next;
    logic [ROW_W-1:0]  tr_col_reg, tr_col_next;
    logic [COST_W-1:0] tr_cost_reg, tr_cost_next;

    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [ROW_W-1:0]  out_col_reg, out_col_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    logic              out_found_reg, out_found_next;
    logic              out_last_reg, out_last_next;

    logic [DIM_W-1:0]  rows, cols;
    logic [ROW_W-1:0]  rd_row, rd_col;
    logic [COST_W-1:0] rd_g;
    logic [F_W-1:0]    rd_f;
    logic [DIM_W-1:0]  nb_row4, nb_col4;
    logic              nb_in;
    logic [AW-1:0]     nb_idx;
    logic              nb_push;
    logic [AW-1:0]     start_idx;
    logic              map_in_range;

    assign rows = clamp_dim(cfg_rows, SIDE);
    assign cols = clamp_dim(cfg_cols, SIDE);
    assign {rd_g, rd_col, rd_row} = open_rd_reg;
    assign rd_f = F_W'(rd_g) + F_W'(abs_diff(rd_row, cfg_goal_row))
                + F_W'(abs_diff(rd_col, cfg_goal_col));
    assign start_idx = cell_idx(cfg_start_row, cfg_start_col);
    assign map_in_range = ({1'b0, in_row} < SIDE) && ({1'b0, in_col} < SIDE);

    // Neighbour of the entry being expanded, in 4-bit arithmetic for the bound checks.
    always_comb begin
        nb_row4 = {1'b0, best_row_reg};
        nb_col4 = {1'b0, best_col_reg};
        nb_in   = 1'b0;
        unique case (cmd.dir)
            DIR_UP: begin
                nb_row4 = {1'b0, best_row_reg} - DIM_W'(1);
                nb_in   = (best_row_reg != '0) && (nb_row4 < rows) && (nb_col4 < cols);
            end
            DIR_RIGHT: begin
                nb_col4 = {1'b0, best_col_reg} + DIM_W'(1);
                nb_in   = (nb_row4 < rows) && (nb_col4 < cols);
            end
            DIR_DOWN: begin
                nb_row4 = {1'b0, best_row_reg} + DIM_W'(1);
                nb_in   = (nb_row4 < rows) && (nb_col4 < cols);
            end
            DIR_LEFT: begin
                nb_col4 = {1'b0, best_col_reg} - DIM_W'(1);
                nb_in   = (best_col_reg != '0) && (nb_row4 < rows) && (nb_col4 < cols);
            end
            default: nb_in = 1'b0;
        endcase
    end

    // The neighbour's wall and seen bits were read in the previous cycle, as the
    // direction is held through ST_EXP_RD and ST_EXP_WR.
    assign nb_idx  = cell_idx(nb_row4[ROW_W-1:0], nb_col4[ROW_W-1:0]);
    assign nb_push = cmd.expand && nb_in && !wall_rd_reg && !seen_rd_reg
                   && (count_reg < CNT_W'(CELLS));

    assign sts.start_ok   = ({1'b0, cfg_start_row} < rows) && ({1'b0, cfg_start_col} < cols);
    assign sts.clear_done = (clr_idx_reg == AW'(CELLS - 1));
    assign sts.open_empty = (count_reg == '0);
    assign sts.scan_done  = (scan_idx_reg == count_reg) && !cmp_v_reg;
    assign sts.is_goal    = (best_row_reg == cfg_goal_row) && (best_col_reg == cfg_goal_col);
    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.path_end   = (tr_cost_reg == '0);

    always_comb begin
        wall_we    = 1'b0;
        wall_waddr = cell_idx(in_row, in_col);
        wall_wdata = in_blocked;
        if (cmd.clear && cmd.clear_wall) begin
            wall_we    = 1'b1;
            wall_waddr = clr_idx_reg;
            wall_wdata = 1'b0;
        end else if (cmd.load_map && map_in_range) begin
            wall_we = 1'b1;
        end
    end

    always_comb begin
        seen_we    = 1'b0;
        seen_waddr = nb_idx;
        seen_wdata = 1'b1;
        if (cmd.clear) begin
            seen_we    = 1'b1;
            seen_waddr = clr_idx_reg;
            seen_wdata = 1'b0;
        end else if (cmd.seed) begin
            seen_we    = 1'b1;
            seen_waddr = start_idx;
        end else if (nb_push) begin
            seen_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wall_we) begin
            wall_mem[wall_waddr] <= wall_wdata;
        end
        wall_rd_reg <= wall_mem[nb_idx];
    end

    always_ff @(posedge aclk) begin
        if (seen_we) begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        seen_rd_reg <= seen_mem[nb_idx];
    end

    always_comb begin
        open_raddr = scan_idx_reg[AW-1:0];
        if (cmd.take_rd) begin
            open_raddr = AW'(count_reg - CNT_W'(1));
        end
    end

    always_comb begin
        open_we    = 1'b0;
        open_waddr = count_reg[AW-1:0];
        open_wdata = {COST_W'(best_g_reg + COST_W'(1)), nb_col4[ROW_W-1:0],
                      nb_row4[ROW_W-1:0]};
        came_we    = nb_push;
        came_waddr = nb_idx;
        priority if (cmd.seed) begin
            open_we    = 1'b1;
            open_waddr = '0;
            open_wdata = {COST_W'(0), cfg_start_col, cfg_start_row};
        end else if (cmd.take_wr) begin
            open_we    = 1'b1;
            open_waddr = best_idx_reg;
            open_wdata = open_rd_reg;
        end else if (nb_push) begin
            open_we = 1'b1;
        end else begin
            open_we = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (open_we) begin
            open_mem[open_waddr] <= open_wdata;
        end
        open_rd_reg <= open_mem[open_raddr];
    end

    always_ff @(posedge aclk) begin
        if (came_we) begin
            came_mem[came_waddr] <= cmd.dir;
        end
        came_rd_reg <= came_mem[cell_idx(tr_row_reg, tr_col_reg)];
    end

    always_comb begin
        clr_idx_next   = clr_idx_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_v_next     = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        best_v_next    = best_v_reg;
        best_f_next    = best_f_reg;
        best_idx_next  = best_idx_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        best_g_next    = best_g_reg;
        tr_row_next    = tr_row_reg;
        tr_col_next    = tr_col_reg;
        tr_cost_next   = tr_cost_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_cost_next  = out_cost_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;

        if (cmd.clear) begin
            clr_idx_next = sts.clear_done ? '0 : clr_idx_reg + AW'(1);
        end
        if (cmd.init) begin
            count_next = '0;
        end
        if (cmd.seed) begin
            count_next = CNT_W'(1);
        end
        if (cmd.scan_start) begin
            scan_idx_next = '0;
            best_v_next   = 1'b0;
        end
        if (cmd.scan_step) begin
            if (scan_idx_reg != count_reg) begin
                cmp_v_next    = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
            // Strict compare keeps the earliest entry on a tie.
            if (cmp_v_reg && (!best_v_reg || (rd_f < best_f_reg))) begin
                best_v_next   = 1'b1;
                best_f_next   = rd_f;
                best_idx_next = cmp_idx_reg[AW-1:0];
                best_row_next = rd_row;
                best_col_next = rd_col;
                best_g_next   = rd_g;
            end
        end
        if (cmd.take_wr) begin
            count_next   = count_reg - CNT_W'(1);
            tr_row_next  = best_row_reg;
            tr_col_next  = best_col_reg;
            tr_cost_next = best_g_reg;
        end
        if (nb_push) begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.nf_emit) begin
            out_valid_next = 1'b1;
            out_row_next   = '0;
            out_col_next   = '0;
            out_cost_next  = '0;
            out_found_next = 1'b0;
            out_last_next  = 1'b1;
        end
        if (cmd.tr_emit) begin
            out_valid_next = 1'b1;
            out_row_next   = tr_row_reg;
            out_col_next   = tr_col_reg;
            out_cost_next  = tr_cost_reg;
            out_found_next = 1'b1;
            out_last_next  = (tr_cost_reg == '0);
        end
        if (cmd.tr_step) begin
            tr_cost_next = tr_cost_reg - COST_W'(1);
            unique case (came_rd_reg)
                DIR_UP:    tr_row_next = tr_row_reg + ROW_W'(1);
                DIR_RIGHT: tr_col_next = tr_col_reg - ROW_W'(1);
                DIR_DOWN:  tr_row_next = tr_row_reg - ROW_W'(1);
                DIR_LEFT:  tr_col_next = tr_col_reg + ROW_W'(1);
                default:   tr_row_next = tr_row_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            cmp_v_reg     <= 1'b0;
            best_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            cmp_v_reg     <= cmp_v_next;
            best_v_reg    <= best_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_f_reg   <= best_f_next;
        best_idx_reg <= best_idx_next;
        best_row_reg <= best_row_next;
        best_col_reg <= best_col_next;
        best_g_reg   <= best_g_next;
        tr_row_reg   <= tr_row_next;
        tr_col_reg   <= tr_col_next;
        tr_cost_reg  <= tr_cost_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_cost_reg <= out_cost_next;
        out_found_reg <= out_found_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_cost  = out_cost_reg;
    assign out_found = out_found_reg;
    assign out_last  = out_last_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CELLS))
    `ASSERT_IMPLIES(a_take_nonempty, cmd.take_wr, count_reg != '0)
    `ASSERT_NEXT(a_nf_result, cmd.nf_emit, out_valid_reg && !out_found_reg && out_last_reg)
    `ASSERT_NEXT(a_path_result, cmd.tr_emit, out_valid_reg && out_found_reg)

endmodule

>>> sv/grid_astar_path_search.sv
// Top level of the grid A* path search: configuration registers, controller and datapath.
//
// The block takes map transactions on the s_ stream, one per cycle while idle, each writing
// the wall flag of one cell; the transaction with tlast set also starts an A* search from the
// configured start to the configured goal over the grid area in use, with unit move costs and
// the Manhattan distance as heuristic. During the search the input stays stalled. A search
// opens in ST_INIT; a pass then clears the seen map one cell per cycle, and ST_SEED puts the
// start cell on the open list. Each expansion scans the open list through a single memory
// read port, one entry per cycle, and then tries the four neighbours, each through ST_EXP_RD
// and ST_EXP_WR. A grid of 64 cells needs at most 64 expansions. The result is either the
// path from goal back to start, one m_ transaction per cell in ST_TR_EMIT with a step back in
// ST_TR_STEP between cells, or one not-found transaction. The wall map survives across
// searches; after reset a clearing pass wipes it, and s_tready stays low until it is done.
// Configuration registers may be written over the APB-style port only while the block is idle.
`include "assert_macros.svh"
module grid_astar_path_search #(
    parameter int GRID_SIDE = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] cell_row, [5:3] cell_col, [6] blocked, [7] zero
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] path_row, [5:3] path_col, [11:6] path_cost, rest zero
    output logic        m_tuser,   // found
    output logic        m_tlast,   // last_of_path
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gaps_pkg::*;

    logic [DIM_W-1:0] grid_rows_reg, grid_cols_reg;
    logic [ROW_W-1:0] start_row_reg, start_col_reg, goal_row_reg, goal_col_reg;
    logic [2:0]       reg_idx;
    logic             cfg_wr;

    cmd_t    cmd;
    status_t sts;
    logic    in_ready;
    logic    in_fire;

    logic [ROW_W-1:0]  out_row, out_col;
    logic [COST_W-1:0] out_cost;

    // Register i sits at byte address 4*i; the low two address bits are ignored.
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= DIM_W'(8);
            grid_cols_reg <= DIM_W'(8);
            start_row_reg <= '0;
            start_col_reg <= '0;
            goal_row_reg  <= ROW_W'(7);
            goal_col_reg  <= ROW_W'(7);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GRID_ROWS: grid_rows_reg <= pwdata[DIM_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= pwdata[DIM_W-1:0];
                REG_START_ROW: start_row_reg <= pwdata[ROW_W-1:0];
                REG_START_COL: start_col_reg <= pwdata[ROW_W-1:0];
                REG_GOAL_ROW:  goal_row_reg  <= pwdata[ROW_W-1:0];
                REG_GOAL_COL:  goal_col_reg  <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_GRID_ROWS: prdata = 32'(grid_rows_reg);
            REG_GRID_COLS: prdata = 32'(grid_cols_reg);
            REG_START_ROW: prdata = 32'(start_row_reg);
            REG_START_COL: prdata = 32'(start_col_reg);
            REG_GOAL_ROW:  prdata = 32'(goal_row_reg);
            REG_GOAL_COL:  prdata = 32'(goal_col_reg);
            default:       prdata = '0;
        endcase
    end

    assign s_tready = in_ready;
    assign in_fire  = s_tvalid && in_ready;

    gaps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_last  (s_tlast),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    gaps_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_row        (s_tdata[2:0]),
        .in_col        (s_tdata[5:3]),
        .in_blocked    (s_tdata[6]),
        .cfg_rows      (grid_rows_reg),
        .cfg_cols      (grid_cols_reg),
        .cfg_start_row (start_row_reg),
        .cfg_start_col (start_col_reg),
        .cfg_goal_row  (goal_row_reg),
        .cfg_goal_col  (goal_col_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_cost      (out_cost),
        .out_found     (m_tuser),
        .out_last      (m_tlast)
    );

    assign m_tdata = {4'b0000, out_cost, out_col, out_row};

    `ASSERT_IMPLIES(a_no_input_in_search, s_tready, !cmd.scan_step && !cmd.expand)
    `ASSERT_NEXT(a_last_starts_search, in_fire && s_tlast, !s_tready)
    `ASSERT_IMPLIES(a_cfg_idle_ready, cmd.init, !s_tready)

endmodule

>>> bench/grid_astar_path_search_test.sv
// Self-checking testbench of the grid A* path search block: driven map streams against a behavioural search predictor.
//
// Map transactions are queued by an initial block and sent by a clocked driver with random gaps.
// Every transaction with tlast set starts a search; the predictor runs the same A* search on its
// own copy of the wall map and registers and queues the expected path cells. A clocked monitor
// takes the result transactions with random stalls and compares them field by field with the
// oldest expected cell. Registers are written over the APB-style port only while the block is
// idle, which is between phases once every expected cell has come back.
module grid_astar_path_search_test;
    import gaps_pkg::*;

    localparam int SIDE  = 8;
    localparam int CELLS = SIDE * SIDE;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       blocked;
        logic       last;
    } map_item_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic [5:0] cost;
        logic       found;
        logic       last;
    } path_cell_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_astar_path_search #(.GRID_SIDE(SIDE)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    // Predictor state: register copies and the wall map, kept across searches.
    logic [3:0] cfg_rows, cfg_cols;
    logic [2:0] cfg_start_row, cfg_start_col, cfg_goal_row, cfg_goal_col;
    logic       wall [CELLS];

    map_item_t  pending_maps[$];
    path_cell_t expected_cells[$];
    int         error_count;
    int         idle_cycles;
    bit         stimulus_done;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic int manhattan(input int idx);
        int r, c;
        r = idx / SIDE;
        c = idx % SIDE;
        return (r > cfg_goal_row ? r - cfg_goal_row : cfg_goal_row - r)
             + (c > cfg_goal_col ? c - cfg_goal_col : cfg_goal_col - c);
    endfunction

    function automatic void push_cell(input int r, input int c, input int cost,
                                      input bit fnd, input bit lst);
        path_cell_t p;
        p.row = r[2:0];
        p.col = c[2:0];
        p.cost = cost[5:0];
        p.found = fnd;
        p.last = lst;
        expected_cells = {expected_cells, p};
    endfunction

    // A* search with the block's tie rule (earliest list entry) and swap-with-last removal.
    function automatic void predict_search();
        int  rows, cols, startc, goalc, count, best, bestf, f, cur, g, r, c, nr, nc, n, cost;
        int  list_cell [CELLS];
        int  list_cost [CELLS];
        bit  seen [CELLS];
        logic [1:0] came [CELLS];
        bit  hit;
        rows = (cfg_rows == 0) ? 1 : (cfg_rows > SIDE ? SIDE : cfg_rows);
        cols = (cfg_cols == 0) ? 1 : (cfg_cols > SIDE ? SIDE : cfg_cols);
        foreach (seen[i]) begin
            seen[i] = 1'b0;
            came[i] = DIR_UP;
        end
        if (cfg_start_row >= rows || cfg_start_col >= cols) begin
            push_cell(0, 0, 0, 1'b0, 1'b1);
            return;
        end
        startc = cfg_start_row * SIDE + cfg_start_col;
        goalc = cfg_goal_row * SIDE + cfg_goal_col;
        list_cell[0] = startc;
        list_cost[0] = 0;
        count = 1;
        seen[startc] = 1'b1;
        hit = 1'b0;
        g = 0;
        while (count > 0 && !hit) begin
            best = 0;
            bestf = list_cost[0] + manhattan(list_cell[0]);
            for (int i = 1; i < count; i++) begin
                f = list_cost[i] + manhattan(list_cell[i]);
                if (f < bestf) begin
                    bestf = f;
                    best = i;
                end
            end
            cur = list_cell[best];
            g = list_cost[best];
            list_cell[best] = list_cell[count - 1];
            list_cost[best] = list_cost[count - 1];
            count--;
            if (cur == goalc) begin
                hit = 1'b1;
            end else begin
                r = cur / SIDE;
                c = cur % SIDE;
                for (int d = 0; d < 4; d++) begin
                    nr = r + (d == DIR_DOWN) - (d == DIR_UP);
                    nc = c + (d == DIR_RIGHT) - (d == DIR_LEFT);
                    if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
                    n = nr * SIDE + nc;
                    if (wall[n] || seen[n] || count >= CELLS) continue;
                    seen[n] = 1'b1;
                    came[n] = d[1:0];
                    list_cell[count] = n;
                    list_cost[count] = (g + 1) & 63;
                    count++;
                end
            end
        end
        if (!hit) begin
            push_cell(0, 0, 0, 1'b0, 1'b1);
            return;
        end
        // Walk back from the goal by undoing each recorded move.
        n = goalc;
        cost = g;
        for (int k = 0; k < CELLS; k++) begin
            r = n / SIDE;
            c = n % SIDE;
            push_cell(r, c, cost, 1'b1, cost == 0);
            if (cost == 0) break;
            case (came[n])
                DIR_UP:    r++;
                DIR_RIGHT: c--;
                DIR_DOWN:  r--;
                default:   c++;
            endcase
            n = (r * SIDE + c) % CELLS;
            cost--;
        end
    endfunction

    // Random sender gaps: mostly none at all, sometimes short, now and then long.
    int send_gap;
    function automatic bit s_tvalid_hold();
        if (send_gap > 0) begin
            send_gap--;
            return 1'b1;
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3: send_gap = $urandom_range(0, 2);
            4:          send_gap = $urandom_range(5, 30);
            default:    send_gap = 0;
        endcase
        return send_gap > 0;
    endfunction

    // Driver: presents queued map cells with random gaps; the predictor runs on acceptance.
    always @(posedge aclk) begin
        map_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            foreach (wall[i]) wall[i] = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                it = pending_maps.pop_front();
                wall[{it.row, it.col}] = it.blocked;
                if (it.last) predict_search();
            end
            if ((!s_tvalid || s_tready) && pending_maps.size() > 0 && !s_tvalid_hold()) begin
                it = pending_maps[(s_tvalid && s_tready) ? 0 : 0];
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, it.blocked, it.col, it.row};
                s_tlast <= it.last;
            end else if (!s_tvalid || s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls on tready, checks every result transaction in order.
    int recv_gap;
    always @(posedge aclk) begin
        path_cell_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch("unexpected result, path_row", m_tdata[2:0], 0);
                end else begin
                    want = expected_cells.pop_front();
                    if (m_tdata[2:0] !== want.row)
                        report_mismatch("path_row", m_tdata[2:0], want.row);
                    if (m_tdata[5:3] !== want.col)
                        report_mismatch("path_col", m_tdata[5:3], want.col);
                    if (m_tdata[11:6] !== want.cost)
                        report_mismatch("path_cost", m_tdata[11:6], want.cost);
                    if (m_tuser !== want.found)
                        report_mismatch("found", m_tuser, want.found);
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_path", m_tlast, want.last);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2:  recv_gap = $urandom_range(1, 3);
                    3:        recv_gap = $urandom_range(5, 40);
                    default:  recv_gap = 0;
                endcase
                m_tready <= (recv_gap == 0);
            end
        end
    end

    // Watchdog: a long run of cycles with no transaction on either side ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT && !stimulus_done) begin
                $display("grid_astar_path_search: mismatch");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [2:0] index, input logic [3:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {28'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_GRID_ROWS: cfg_rows = value;
            REG_GRID_COLS: cfg_cols = value;
            REG_START_ROW: cfg_start_row = value[2:0];
            REG_START_COL: cfg_start_col = value[2:0];
            REG_GOAL_ROW:  cfg_goal_row = value[2:0];
            default:       cfg_goal_col = value[2:0];
        endcase
    endtask

    task automatic set_search(input int rows, input int cols, input int sr, input int sc,
                              input int gr, input int gc);
        write_register(REG_GRID_ROWS, rows[3:0]);
        write_register(REG_GRID_COLS, cols[3:0]);
        write_register(REG_START_ROW, sr[3:0]);
        write_register(REG_START_COL, sc[3:0]);
        write_register(REG_GOAL_ROW, gr[3:0]);
        write_register(REG_GOAL_COL, gc[3:0]);
    endtask

    // Waits until the block has taken everything and returned every expected path cell.
    task automatic drain();
        while (pending_maps.size() > 0 || s_tvalid || expected_cells.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic void queue_map(input int r, input int c, input bit b, input bit l);
        map_item_t it;
        it.row = r[2:0];
        it.col = c[2:0];
        it.blocked = b;
        it.last = l;
        pending_maps = {pending_maps, it};
    endfunction

    initial begin
        int sent;
        int burst;
        stimulus_done = 1'b0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_rows = 4'd8;
        cfg_cols = 4'd8;
        cfg_start_row = 3'd0;
        cfg_start_col = 3'd0;
        cfg_goal_row = 3'd7;
        cfg_goal_col = 3'd7;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: open grid with reset registers, then corner to corner the other way.
        queue_map(0, 0, 1'b0, 1'b1);
        drain();
        set_search(8, 8, 7, 7, 0, 0);
        queue_map(7, 7, 1'b0, 1'b0);
        queue_map(3, 4, 1'b1, 1'b0);
        queue_map(7, 0, 1'b1, 1'b1);
        drain();
        // Blocked start still searched from; blocked goal reached only when equal to start.
        set_search(4, 4, 1, 1, 1, 1);
        queue_map(1, 1, 1'b1, 1'b1);
        drain();
        set_search(4, 4, 0, 0, 2, 2);
        queue_map(2, 2, 1'b1, 1'b1);
        drain();
        // Start outside the area, goal outside the area, zero and oversized dimensions.
        set_search(3, 3, 5, 0, 0, 0);
        queue_map(0, 1, 1'b0, 1'b1);
        drain();
        set_search(3, 3, 0, 0, 6, 6);
        queue_map(2, 2, 1'b0, 1'b1);
        drain();
        set_search(0, 15, 0, 0, 0, 7);
        queue_map(2, 2, 1'b0, 1'b1);
        drain();
        set_search(15, 0, 0, 0, 7, 0);
        queue_map(1, 0, 1'b0, 1'b1);
        drain();
        // Wall across the whole grid gives not-found; reopening gives a detour.
        set_search(8, 8, 0, 3, 7, 3);
        for (int c = 0; c < 8; c++) queue_map(4, c, 1'b1, c == 7);
        drain();
        queue_map(4, 7, 1'b0, 1'b1);
        drain();
        for (int c = 0; c < 8; c++) queue_map(4, c, 1'b0, 1'b0);

        // Random phases: new registers between searches, map bursts ending in a search.
        sent = 30;
        while (sent < 500) begin
            drain();
            if ($urandom_range(0, 3) == 0)
                set_search($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                           $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
            else
                set_search($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(0, 7),
                           $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++)
                queue_map($urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 3) == 0, k == burst - 1);
            sent += burst;
        end
        drain();
        repeat (200) @(posedge aclk);
        stimulus_done = 1'b1;
        if (error_count == 0 && expected_cells.size() == 0) begin
            $display("grid_astar_path_search: match");
        end else begin
            $display("grid_astar_path_search: mismatch");
        end
        $finish;
    end
endmodule
